@@ src/uu_pkg.sv @@
// Shared types, rule table and match helper for the uppercase mapping pipeline.
// No dependencies; imported by every module of the block.
package uu_pkg;

    localparam int CpW        = 21;
    localparam int ArgW       = 11;
    localparam int RuleCount  = 114;
    localparam int IdxW       = $clog2(RuleCount);
    localparam int GroupSize  = 16;
    localparam int GroupCount = (RuleCount + GroupSize - 1) / GroupSize;
    localparam int LocW       = $clog2(GroupSize);
    localparam int GrpW       = $clog2(GroupCount);

    typedef enum logic [2:0] {
        MODE_SUB,
        MODE_ODD,
        MODE_EVEN,
        MODE_SET,
        MODE_KEEP,
        MODE_GRK
    } t_mode;

    typedef struct packed {
        logic [CpW-1:0]  lo;
        logic [CpW-1:0]  hi;
        t_mode           mode;
        logic [ArgW-1:0] arg;
    } t_rule;

    // Stage after the range compares
    typedef struct packed {
        logic                 valid;
        logic [CpW-1:0]       cp;
        logic [RuleCount-1:0] match;
    } t_s1;

    // Stage after the per-group priority encode
    typedef struct packed {
        logic                             valid;
        logic [CpW-1:0]                   cp;
        logic [GroupCount-1:0]            grp_hit;
        logic [GroupCount-1:0][LocW-1:0]  loc;
    } t_s2;

    // Stage after the rule lookup
    typedef struct packed {
        logic            valid;
        logic [CpW-1:0]  cp;
        logic            hit;
        t_mode           mode;
        logic [ArgW-1:0] arg;
    } t_s3;

    // Ordered rule list: the lowest index that matches decides.
    localparam t_rule Rules [RuleCount] = '{
        '{21'h00061, 21'h0007B, MODE_SUB,  11'h020},
        '{21'h000E0, 21'h000FF, MODE_SUB,  11'h020},
        '{21'h000FF, 21'h00100, MODE_SET,  11'h178},
        '{21'h00100, 21'h00130, MODE_ODD,  11'h000},
        '{21'h00131, 21'h00132, MODE_SET,  11'h049},
        '{21'h00132, 21'h00138, MODE_ODD,  11'h000},
        '{21'h00139, 21'h00149, MODE_EVEN, 11'h000},
        '{21'h0014A, 21'h00178, MODE_ODD,  11'h000},
        '{21'h00179, 21'h0017F, MODE_EVEN, 11'h000},
        '{21'h00182, 21'h00186, MODE_ODD,  11'h000},
        '{21'h00188, 21'h00189, MODE_SUB,  11'h001},
        '{21'h0018C, 21'h0018D, MODE_SUB,  11'h001},
        '{21'h00192, 21'h00193, MODE_SUB,  11'h001},
        '{21'h00199, 21'h0019A, MODE_SUB,  11'h001},
        '{21'h001A0, 21'h001A6, MODE_EVEN, 11'h000},
        '{21'h001A8, 21'h001A9, MODE_SUB,  11'h001},
        '{21'h001AD, 21'h001AE, MODE_SUB,  11'h001},
        '{21'h001B0, 21'h001B1, MODE_SUB,  11'h001},
        '{21'h001B4, 21'h001B5, MODE_SUB,  11'h001},
        '{21'h001B6, 21'h001B7, MODE_SUB,  11'h001},
        '{21'h001B9, 21'h001BA, MODE_SUB,  11'h001},
        '{21'h001BD, 21'h001BE, MODE_SUB,  11'h001},
        '{21'h001C6, 21'h001C7, MODE_SUB,  11'h001},
        '{21'h001C9, 21'h001CA, MODE_SUB,  11'h001},
        '{21'h001CC, 21'h001CD, MODE_SUB,  11'h001},
        '{21'h001CD, 21'h001DD, MODE_EVEN, 11'h000},
        '{21'h001DE, 21'h001F0, MODE_ODD,  11'h000},
        '{21'h001F3, 21'h001F4, MODE_SET,  11'h1F1},
        '{21'h001F5, 21'h001F6, MODE_SUB,  11'h001},
        '{21'h001F8, 21'h00220, MODE_ODD,  11'h000},
        '{21'h00253, 21'h00254, MODE_SET,  11'h181},
        '{21'h00254, 21'h00255, MODE_SET,  11'h186},
        '{21'h00257, 21'h00258, MODE_SET,  11'h18A},
        '{21'h00258, 21'h00259, MODE_SET,  11'h18E},
        '{21'h00259, 21'h0025A, MODE_SET,  11'h18F},
        '{21'h0025B, 21'h0025C, MODE_SET,  11'h190},
        '{21'h00260, 21'h00261, MODE_SET,  11'h193},
        '{21'h00263, 21'h00264, MODE_SET,  11'h194},
        '{21'h00268, 21'h00269, MODE_SET,  11'h197},
        '{21'h00269, 21'h0026A, MODE_SET,  11'h196},
        '{21'h0026F, 21'h00270, MODE_SET,  11'h19C},
        '{21'h00272, 21'h00273, MODE_SET,  11'h19D},
        '{21'h00275, 21'h00276, MODE_SET,  11'h19F},
        '{21'h00283, 21'h00284, MODE_SET,  11'h1A9},
        '{21'h00288, 21'h00289, MODE_SET,  11'h1AE},
        '{21'h0028A, 21'h0028B, MODE_SET,  11'h1B1},
        '{21'h0028B, 21'h0028C, MODE_SET,  11'h1B2},
        '{21'h00292, 21'h00293, MODE_SET,  11'h1B7},
        '{21'h003AC, 21'h003AD, MODE_SET,  11'h386},
        '{21'h003AD, 21'h003AE, MODE_SET,  11'h388},
        '{21'h003AE, 21'h003AF, MODE_SET,  11'h389},
        '{21'h003AF, 21'h003B0, MODE_SET,  11'h38A},
        '{21'h003C2, 21'h003C3, MODE_KEEP, 11'h000},
        '{21'h003CC, 21'h003CD, MODE_SET,  11'h38C},
        '{21'h003CD, 21'h003CE, MODE_SET,  11'h38E},
        '{21'h003CE, 21'h003CF, MODE_SET,  11'h38F},
        '{21'h003B1, 21'h003CC, MODE_SUB,  11'h020},
        '{21'h003E2, 21'h003F0, MODE_ODD,  11'h000},
        '{21'h00430, 21'h00450, MODE_SUB,  11'h020},
        '{21'h00450, 21'h00460, MODE_SUB,  11'h050},
        '{21'h00460, 21'h00482, MODE_ODD,  11'h000},
        '{21'h0048A, 21'h004C0, MODE_ODD,  11'h000},
        '{21'h004C1, 21'h004CF, MODE_EVEN, 11'h000},
        '{21'h004CF, 21'h004D0, MODE_SET,  11'h4C0},
        '{21'h004D0, 21'h00530, MODE_ODD,  11'h000},
        '{21'h00561, 21'h00587, MODE_SUB,  11'h030},
        '{21'h010D0, 21'h01100, MODE_SUB,  11'h030},
        '{21'h01E00, 21'h01E96, MODE_ODD,  11'h000},
        '{21'h01EA0, 21'h01F00, MODE_ODD,  11'h000},
        '{21'h01F00, 21'h02000, MODE_GRK,  11'h000},
        '{21'h02170, 21'h02180, MODE_SUB,  11'h010},
        '{21'h024D0, 21'h024EA, MODE_SUB,  11'h01A},
        '{21'h02C30, 21'h02C60, MODE_SUB,  11'h030},
        '{21'h02C61, 21'h02C62, MODE_SUB,  11'h001},
        '{21'h02C68, 21'h02C69, MODE_SUB,  11'h001},
        '{21'h02C6A, 21'h02C6B, MODE_SUB,  11'h001},
        '{21'h02C6C, 21'h02C6D, MODE_SUB,  11'h001},
        '{21'h02C73, 21'h02C74, MODE_SUB,  11'h001},
        '{21'h02C76, 21'h02C77, MODE_SUB,  11'h001},
        '{21'h02C80, 21'h02CE4, MODE_ODD,  11'h000},
        '{21'h02CEC, 21'h02CED, MODE_SUB,  11'h001},
        '{21'h02CEE, 21'h02CEF, MODE_SUB,  11'h001},
        '{21'h02CF3, 21'h02CF4, MODE_SUB,  11'h001},
        '{21'h0A640, 21'h0A66E, MODE_ODD,  11'h000},
        '{21'h0A680, 21'h0A69C, MODE_ODD,  11'h000},
        '{21'h0A722, 21'h0A730, MODE_ODD,  11'h000},
        '{21'h0A732, 21'h0A770, MODE_ODD,  11'h000},
        '{21'h0A779, 21'h0A77D, MODE_EVEN, 11'h000},
        '{21'h0A780, 21'h0A788, MODE_ODD,  11'h000},
        '{21'h0A790, 21'h0A794, MODE_ODD,  11'h000},
        '{21'h0A79A, 21'h0A7AA, MODE_ODD,  11'h000},
        '{21'h0A7B6, 21'h0A7C4, MODE_ODD,  11'h000},
        '{21'h0A7C7, 21'h0A7CB, MODE_ODD,  11'h000},
        '{21'h0FF41, 21'h0FF5B, MODE_SUB,  11'h020},
        '{21'h10428, 21'h10450, MODE_SUB,  11'h028},
        '{21'h104D8, 21'h10500, MODE_SUB,  11'h028},
        '{21'h1D41A, 21'h1D434, MODE_SUB,  11'h01A},
        '{21'h1D44E, 21'h1D468, MODE_SUB,  11'h01A},
        '{21'h1D482, 21'h1D49C, MODE_SUB,  11'h01A},
        '{21'h1D4B6, 21'h1D4D0, MODE_SUB,  11'h01A},
        '{21'h1D4EA, 21'h1D504, MODE_SUB,  11'h01A},
        '{21'h1D51E, 21'h1D538, MODE_SUB,  11'h01A},
        '{21'h1D552, 21'h1D56C, MODE_SUB,  11'h01A},
        '{21'h1D586, 21'h1D5A0, MODE_SUB,  11'h01A},
        '{21'h1D5BA, 21'h1D5D4, MODE_SUB,  11'h01A},
        '{21'h1D5EE, 21'h1D608, MODE_SUB,  11'h01A},
        '{21'h1D622, 21'h1D63C, MODE_SUB,  11'h01A},
        '{21'h1D656, 21'h1D670, MODE_SUB,  11'h01A},
        '{21'h1D68A, 21'h1D6A4, MODE_SUB,  11'h01A},
        '{21'h1D6C2, 21'h1D6DB, MODE_SUB,  11'h01A},
        '{21'h1D6FC, 21'h1D715, MODE_SUB,  11'h01A},
        '{21'h1D736, 21'h1D74F, MODE_SUB,  11'h01A},
        '{21'h1D770, 21'h1D789, MODE_SUB,  11'h01A},
        '{21'h1D7AA, 21'h1D7C3, MODE_SUB,  11'h01A}
    };

    // A stepping rule whose parity does not fit is a miss, not a stop.
    function automatic logic rule_hits(input logic [CpW-1:0] cp, input t_rule r);
        logic in_rng;
        logic hit;
        in_rng = (cp >= r.lo) && (cp < r.hi);
        unique case (r.mode)
            MODE_ODD:  hit = in_rng && cp[0];
            MODE_EVEN: hit = in_rng && !cp[0];
            MODE_GRK:  hit = in_rng && !cp[3];
            default:   hit = in_rng;
        endcase
        return hit;
    endfunction

    function automatic t_rule rule_at(input logic [IdxW-1:0] idx);
        t_rule r;
        r = '0;
        if (int'(idx) < RuleCount) begin
            r = Rules[idx];
        end
        return r;
    endfunction

endpackage

@@ src/uu_match.sv @@
// First pipeline stage: compares the code point against every rule in parallel.
// Depends on uu_pkg for the rule table and the stage struct.
module uu_match
    import uu_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  logic [CpW-1:0] i_cp,
    output t_s1            o_s1
);

    logic                 r_vld;
    logic [CpW-1:0]       r_cp;
    logic [RuleCount-1:0] r_match;
    logic [RuleCount-1:0] n_match;

    always_comb begin
        for (int i = 0; i < RuleCount; i++) begin
            n_match[i] = rule_hits(i_cp, Rules[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp    <= i_cp;
        r_match <= n_match;
    end

    assign o_s1 = '{valid: r_vld, cp: r_cp, match: r_match};

endmodule

@@ src/uu_group.sv @@
// Second pipeline stage: finds the first matching rule within each group of rules.
// Depends on uu_pkg for the group sizing and the stage structs.
module uu_group
    import uu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_s1  i_s1,
    output t_s2  o_s2
);

    logic                                r_vld;
    logic [CpW-1:0]                      r_cp;
    logic [GroupCount-1:0]               r_grp_hit;
    logic [GroupCount-1:0][LocW-1:0]     r_loc;
    logic [GroupCount-1:0]               n_grp_hit;
    logic [GroupCount-1:0][LocW-1:0]     n_loc;
    logic [GroupCount*GroupSize-1:0]     match_pad;

    // Pad the last group with misses so every group is full width.
    assign match_pad = {{(GroupCount * GroupSize - RuleCount){1'b0}}, i_s1.match};

    // Walk down so the lowest matching rule in each group is kept.
    always_comb begin
        for (int g = 0; g < GroupCount; g++) begin
            n_grp_hit[g] = 1'b0;
            n_loc[g]     = '0;
            for (int j = GroupSize - 1; j >= 0; j--) begin
                if (match_pad[g * GroupSize + j]) begin
                    n_grp_hit[g] = 1'b1;
                    n_loc[g]     = LocW'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp      <= i_s1.cp;
        r_grp_hit <= n_grp_hit;
        r_loc     <= n_loc;
    end

    assign o_s2 = '{valid: r_vld, cp: r_cp, grp_hit: r_grp_hit, loc: r_loc};

endmodule

@@ src/uu_select.sv @@
// Third pipeline stage: picks the first group that hit and reads the winning rule.
// Depends on uu_pkg for the rule table lookup and the stage structs.
module uu_select
    import uu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_s2  i_s2,
    output t_s3  o_s3
);

    logic            r_vld;
    logic [CpW-1:0]  r_cp;
    logic            r_hit;
    t_mode           r_mode;
    logic [ArgW-1:0] r_arg;

    logic [GrpW-1:0] sel;
    logic [IdxW-1:0] idx;
    t_rule           rule;

    always_comb begin
        sel = '0;
        for (int g = GroupCount - 1; g >= 0; g--) begin
            if (i_s2.grp_hit[g]) begin
                sel = GrpW'(g);
            end
        end
        idx  = IdxW'(int'(sel) * GroupSize + int'(i_s2.loc[sel]));
        rule = rule_at(idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp   <= i_s2.cp;
        r_hit  <= |i_s2.grp_hit;
        r_mode <= rule.mode;
        r_arg  <= rule.arg;
    end

    assign o_s3 = '{valid: r_vld, cp: r_cp, hit: r_hit, mode: r_mode, arg: r_arg};

endmodule

@@ src/unicode_to_uppercase.sv @@
// Uppercase mapping of one code point: compare, group encode, rule lookup, apply.
// o_done rises after the match, group, select and output registers.
// Throughput: one transaction per cycle; busy is low whenever reset is released.
// Reset (synchronous, active low) clears the valid bits of every stage only.
// Results are strobed for one cycle and the receiver cannot stall the pipeline.
// Depends on uu_pkg, uu_match, uu_group and uu_select.
module unicode_to_uppercase
    import uu_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic [CpW-1:0] i_code_point,
    output logic           o_done,
    output logic [CpW-1:0] o_upper_point
);

    t_s1 s1;
    t_s2 s2;
    t_s3 s3;

    logic           r_done;
    logic [CpW-1:0] r_upper;
    logic [CpW-1:0] n_upper;

    // Hold off transactions only while reset is asserted.
    assign busy = !i_rst_n;

    uu_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_cp    (i_code_point),
        .o_s1    (s1)
    );

    uu_group u_group (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    uu_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s2    (s2),
        .o_s3    (s3)
    );

    always_comb begin
        n_upper = s3.cp;
        if (s3.hit) begin
            unique case (s3.mode)
                MODE_SUB:  n_upper = s3.cp - CpW'(s3.arg);
                MODE_SET:  n_upper = CpW'(s3.arg);
                MODE_KEEP: n_upper = s3.cp;
                MODE_ODD:  n_upper = s3.cp - CpW'(1);
                MODE_EVEN: n_upper = s3.cp - CpW'(1);
                MODE_GRK:  n_upper = s3.cp + CpW'(8);
                default:   n_upper = s3.cp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= s3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_upper <= n_upper;
    end

    assign o_done        = r_done;
    assign o_upper_point = r_upper;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("accepted transaction did not complete after four cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 4))
        else $error("result strobed without a matching transaction");

    a_high_plane_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(i_code_point, 4) >= 21'h20000))
            |-> (o_upper_point == $past(i_code_point, 4)))
        else $error("code point above the mapped planes was altered");

endmodule
